@@ src/sgs_pkg.sv @@
// ----------------------------------------------------------------------------
// sgs_pkg: shared types and constants for the Sobel gradient stream core
// Field widths, frame limits, register indexes and the job record that
// travels from the front end through the queue to the gradient back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sgs_pkg;

  // Field widths
  localparam int PIX_W        = 8;
  localparam int GRAD_W       = 11;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;

  // Register reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // One classified result request: the 3x3 taps (center unused) and tags
  typedef struct packed {
    logic [PIX_W-1:0] tl;
    logic [PIX_W-1:0] tc;
    logic [PIX_W-1:0] tr;
    logic [PIX_W-1:0] ml;
    logic [PIX_W-1:0] mr;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] bc;
    logic [PIX_W-1:0] br;
    logic             interior;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
  } sgs_job_t;

endpackage

`default_nettype wire

@@ src/sgs_stream_if.sv @@
// ----------------------------------------------------------------------------
// sgs stream interfaces: pixel input channel and gradient output channel
// Valid/ready channels; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgs_pix_if;
  import sgs_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sgs_grad_if;
  import sgs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] grad_u;
  logic signed [GRAD_W-1:0] grad_v;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic                     frame_end;

  modport source (output valid, output grad_u, output grad_v, output out_row,
                  output out_col, output frame_end, input ready);
  modport sink   (input valid, input grad_u, input grad_v, input out_row,
                  input out_col, input frame_end, output ready);
endinterface

`default_nettype wire

@@ src/sgs_front.sv @@
// ----------------------------------------------------------------------------
// sgs_front: pixel intake, frame counters, line stores and window
// Accepts pixels, tracks row/column, reads both line stores in one 16-bit
// wide memory, shifts the window and hands classified jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  sgs_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sgs_pix_if.sink                        pix_i,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  output sgs_pkg::sgs_job_t              job_o
);
  import sgs_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [COL_W-1:0]        wm1;
  logic [ROW_W-1:0]        hm1;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept;
  logic             row_end, frame_done;
  logic             emit, interior;
  logic [ROW_W-1:0] rr;
  logic [COL_W-1:0] cc;

  // stage 1: pixel accepted, line store read in flight
  logic             s1_valid_q;
  logic             s1_adv;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_addr_q;
  logic             s1_emit_q;
  logic             s1_int_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_fend_q;

  // line stores: [15:8] older row, [7:0] newer row
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0]   top, mid;

  // window columns 1 and 2 for rows top/mid/bottom
  logic [PIX_W-1:0] win_q [3][2];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes into the legal range; keep size minus one
  always_comb begin
    if (width_q < WIDTH_REG_W'(MIN_SIZE)) begin
      wm1 = COL_W'(MIN_SIZE - 1);
    end else if (width_q > WIDTH_REG_W'(MAX_WIDTH)) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(width_q - WIDTH_REG_W'(1));
    end
    if (height_q < HEIGHT_REG_W'(MIN_SIZE)) begin
      hm1 = ROW_W'(MIN_SIZE - 1);
    end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(height_q - HEIGHT_REG_W'(1));
    end
  end

  // Handshake and stage advance
  assign s1_adv      = s1_valid_q && (!s1_emit_q || job_ready_i);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;

  // Classify the incoming pixel
  always_comb begin
    row_end    = (col_q >= wm1);
    frame_done = row_end && (row_q >= hm1);
    emit       = (row_q != '0) && (col_q != '0);
    rr         = row_q - ROW_W'(1);
    cc         = col_q - COL_W'(1);
    interior   = (rr != '0) && (rr < hm1) && (cc != '0) && (cc < wm1);
    if (frame_done) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
      row_d = row_q;
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix_i.pixel;
      s1_addr_q <= col_q;
      s1_emit_q <= emit;
      s1_int_q  <= interior;
      s1_row_q  <= rr;
      s1_col_q  <= cc;
      s1_fend_q <= frame_done;
    end
  end

  // Line stores: read on accept, written back as stage 1 advances.
  // Consecutive pixels never share a column, so read and write never collide.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_adv) begin
      line_mem[s1_addr_q] <= {rd_q[PIX_W-1:0], s1_pix_q};
    end
  end

  assign top = rd_q[2*PIX_W-1:PIX_W];
  assign mid = rd_q[PIX_W-1:0];

  // Window shift as stage 1 retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= '0;
        win_q[k][1] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
      end
      win_q[0][1] <= top;
      win_q[1][1] <= mid;
      win_q[2][1] <= s1_pix_q;
    end
  end

  // Job toward the queue, taps as the shifted window will hold them
  always_comb begin
    job_o.tl        = win_q[0][0];
    job_o.tc        = win_q[0][1];
    job_o.tr        = top;
    job_o.ml        = win_q[1][0];
    job_o.mr        = mid;
    job_o.bl        = win_q[2][0];
    job_o.bc        = win_q[2][1];
    job_o.br        = s1_pix_q;
    job_o.interior  = s1_int_q;
    job_o.row       = s1_row_q;
    job_o.col       = s1_col_q;
    job_o.frame_end = s1_fend_q;
  end

  assign job_valid_o = s1_valid_q && s1_emit_q;

endmodule

`default_nettype wire

@@ src/sgs_queue.sv @@
// ----------------------------------------------------------------------------
// sgs_queue: short job queue between front end and back end
// Register-based FIFO; lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
`default_nettype none

module sgs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sgs_pkg::sgs_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output sgs_pkg::sgs_job_t pop_data_o
);
  import sgs_pkg::*;

  sgs_job_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0]))
    else $error("queue pointers disagree with fill level");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == QCNT_W'(QUEUE_DEPTH)) && !pop |=> $stable(wr_ptr_q))
    else $error("queue written while full");

endmodule

`default_nettype wire

@@ src/sgs_back.sv @@
// ----------------------------------------------------------------------------
// sgs_back: Sobel arithmetic and output register
// Pops a job, forms both gradients (zero off the interior) and holds the
// result in an output register until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sgs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  sgs_pkg::sgs_job_t job_i,
  sgs_grad_if.source        grad_o
);
  import sgs_pkg::*;

  localparam int SUM_W = PIX_W + 2;

  logic [SUM_W-1:0]         u_pos, u_neg, v_pos, v_neg;
  logic signed [GRAD_W-1:0] gu, gv;
  logic                     load;
  logic                     out_valid_q;
  logic signed [GRAD_W-1:0] gu_q, gv_q;
  logic [ROW_W-1:0]         row_q;
  logic [COL_W-1:0]         col_q;
  logic                     fend_q;

  assign job_ready_o = !out_valid_q || grad_o.ready;
  assign load        = job_valid_i && job_ready_o;

  // Gradient sums: outer taps plus doubled center tap on each side
  always_comb begin
    u_pos = SUM_W'(job_i.tr) + {1'b0, job_i.mr, 1'b0} + SUM_W'(job_i.br);
    u_neg = SUM_W'(job_i.tl) + {1'b0, job_i.ml, 1'b0} + SUM_W'(job_i.bl);
    v_pos = SUM_W'(job_i.bl) + {1'b0, job_i.bc, 1'b0} + SUM_W'(job_i.br);
    v_neg = SUM_W'(job_i.tl) + {1'b0, job_i.tc, 1'b0} + SUM_W'(job_i.tr);
    if (job_i.interior) begin
      gu = signed'(GRAD_W'({1'b0, u_pos}) - GRAD_W'({1'b0, u_neg}));
      gv = signed'(GRAD_W'({1'b0, v_pos}) - GRAD_W'({1'b0, v_neg}));
    end else begin
      gu = '0;
      gv = '0;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (grad_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      gu_q   <= gu;
      gv_q   <= gv;
      row_q  <= job_i.row;
      col_q  <= job_i.col;
      fend_q <= job_i.frame_end;
    end
  end

  assign grad_o.valid     = out_valid_q;
  assign grad_o.grad_u    = gu_q;
  assign grad_o.grad_v    = gv_q;
  assign grad_o.out_row   = row_q;
  assign grad_o.out_col   = col_q;
  assign grad_o.frame_end = fend_q;

endmodule

`default_nettype wire

@@ src/sobel_gradient_stream_core.sv @@
// ----------------------------------------------------------------------------
// sobel_gradient_stream_core: streaming 3x3 Sobel gradient engine
// Raster-order 8-bit pixels in, signed horizontal/vertical gradients with
// pixel coordinates out; one result per pixel once a 3x3 window exists.
//
//   channel  dir  handshake      payload
//   pix_i    in   valid/ready    pixel[7:0]
//   grad_o   out  valid/ready    grad_u[10:0] grad_v[10:0] out_row[11:0]
//                                out_col[9:0] frame_end
//   cfg      in   cfg_we_i       cfg_idx_i (0 width, 1 height), cfg_data_i[12:0]
//
// Sustained rate is one pixel per clock while the queue takes jobs; the line
// store memory is read when a pixel is taken and written back on its single
// write port as the pixel leaves stage 1. Results exit via the output register.
// Reset clears the counters and window and loads a 640x480 frame size; the
// line stores are not cleared, as only border results ever see stale data.
// A 4-entry queue between front end and gradient stage absorbs output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_stream_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  sgs_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sgs_pix_if.sink                        pix_i,
  sgs_grad_if.source                     grad_o
);
  import sgs_pkg::*;

  logic     fq_valid, fq_ready;
  sgs_job_t fq_job;
  logic     qb_valid, qb_ready;
  sgs_job_t qb_job;

  // Front end: intake, counters, line stores, window
  sgs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  // Job queue
  sgs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  // Back end: gradient arithmetic and output register
  sgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .grad_o      (grad_o)
  );

endmodule

`default_nettype wire

@@ tb/sgs_grad_checker.sv @@
// ----------------------------------------------------------------------------
// sgs_grad_checker: gradient predictor and result checker
// Watches the pixel, gradient and register-write ports of the Sobel core. It
// keeps its own line stores, 3x3 window and raster counters, and predicts one
// gradient result per accepted pixel once a window exists. Each accepted
// gradient request is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sgs_grad_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  sgs_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sgs_pix_if                             pix_i,
  sgs_grad_if                            grad_i,
  output int                             fail_cnt_o,
  output int                             pending_o,
  output int                             frame_left_o
);
  import sgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_u;
    logic signed [GRAD_W-1:0] grad_v;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     frame_end;
  } grad_res_t;

  // Predicted block state
  logic [PIX_W-1:0]        line_last  [MAX_WIDTH];  // previous row
  logic [PIX_W-1:0]        line_older [MAX_WIDTH];  // row before that
  logic [PIX_W-1:0]        win [9];                 // [3*row + col], oldest first
  int unsigned             col_cnt;
  int unsigned             row_cnt;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  grad_res_t grad_due_q [$];
  int        n_fail;

  // Saturate a size register into the supported range
  function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Pixels still needed to close the current frame at the current sizes
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned rest;
    w = fit_size(32'(width_reg), MAX_WIDTH);
    h = fit_size(32'(height_reg), MAX_HEIGHT);
    rest = (col_cnt >= w - 1) ? 1 : w - col_cnt;
    if (row_cnt < h - 1) rest += (h - 1 - row_cnt) * w;
    return rest;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_fail < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    n_fail++;
  endtask

  task automatic clear_state();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_last[i]  = '0;
      line_older[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_cnt    = 0;
    row_cnt    = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    grad_due_q.delete();
    n_fail     = 0;
  endtask

  // Advance the window by one pixel and queue the result it completes
  task automatic predict_gradient(input logic [PIX_W-1:0] pix);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      rr;
    int unsigned      cc;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    bit               row_done;
    bit               frame_done;
    int               gu;
    int               gv;
    grad_res_t        res;
    w      = fit_size(32'(width_reg), MAX_WIDTH);
    h      = fit_size(32'(height_reg), MAX_HEIGHT);
    c      = col_cnt;
    r      = row_cnt;
    top_px = '0;
    mid_px = '0;
    gu     = 0;
    gv     = 0;

    // line stores shift down one row at this column
    if (c < MAX_WIDTH) begin
      top_px        = line_older[c];
      mid_px        = line_last[c];
      line_older[c] = mid_px;
      line_last[c]  = pix;
    end

    for (int k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = pix;

    // raster counters
    row_done   = (c >= w - 1);
    frame_done = row_done && (r >= h - 1);
    if (frame_done) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (row_done) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end else begin
      col_cnt = c + 1;
    end

    // no result until one full row and column are in
    if (r >= 1 && c >= 1) begin
      rr = r - 1;
      cc = c - 1;
      if (rr >= 1 && rr <= h - 2 && cc >= 1 && cc <= w - 2) begin
        gu = -int'(win[0]) - 2 * int'(win[3]) - int'(win[6])
             + int'(win[2]) + 2 * int'(win[5]) + int'(win[8]);
        gv = -int'(win[0]) - 2 * int'(win[1]) - int'(win[2])
             + int'(win[6]) + 2 * int'(win[7]) + int'(win[8]);
      end
      res.grad_u    = gu[GRAD_W-1:0];
      res.grad_v    = gv[GRAD_W-1:0];
      res.row       = rr[ROW_W-1:0];
      res.col       = cc[COL_W-1:0];
      res.frame_end = frame_done;
      grad_due_q.push_back(res);
    end
  endtask

  task automatic check_result();
    grad_res_t want;
    if (grad_due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result for row %0d col %0d",
                                grad_i.out_row, grad_i.out_col));
      return;
    end
    want = grad_due_q.pop_front();
    if (grad_i.grad_u !== want.grad_u)
      report_mismatch($sformatf("(%0d,%0d) grad_u %0d, expected %0d",
                                want.row, want.col, grad_i.grad_u, want.grad_u));
    if (grad_i.grad_v !== want.grad_v)
      report_mismatch($sformatf("(%0d,%0d) grad_v %0d, expected %0d",
                                want.row, want.col, grad_i.grad_v, want.grad_v));
    if (grad_i.out_row !== want.row)
      report_mismatch($sformatf("out_row %0d, expected %0d", grad_i.out_row, want.row));
    if (grad_i.out_col !== want.col)
      report_mismatch($sformatf("out_col %0d, expected %0d", grad_i.out_col, want.col));
    if (grad_i.frame_end !== want.frame_end)
      report_mismatch($sformatf("(%0d,%0d) frame_end %0b, expected %0b",
                                want.row, want.col, grad_i.frame_end, want.frame_end));
  endtask

  // Results are checked before the same-edge pixel is predicted; a pixel
  // taken at a register-write edge still sees the old sizes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      fail_cnt_o   <= 0;
      pending_o    <= 0;
      frame_left_o <= pixels_to_frame_end();
    end else begin
      if (grad_i.valid && grad_i.ready) check_result();
      if (pix_i.valid && pix_i.ready) predict_gradient(pix_i.pixel);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_WIDTH:  width_reg  = cfg_data_i[WIDTH_REG_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data_i[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      fail_cnt_o   <= n_fail;
      pending_o    <= grad_due_q.size();
      frame_left_o <= pixels_to_frame_end();
    end
  end

endmodule

`default_nettype wire

@@ tb/sobel_gradient_stream_core_tb.sv @@
// ----------------------------------------------------------------------------
// sobel_gradient_stream_core_tb: stimulus and verdict for the Sobel core
// Streams frames at the reset size, directed 3x3 frames with full-scale
// gradients, clamped and extreme frame sizes, size changes inside a frame and
// random small frames, with bursty pixel requests and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_stream_core_tb;
  import sgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_ITEMS   = 200;

  typedef enum int {
    PIX_ANY,
    PIX_BINARY,
    PIX_NEAR_RAIL
  } pix_mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_reg_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_cnt;
  int pending_cnt;
  int frame_left;

  // sender burst state
  int burst_left;
  bit pix_on;
  int pix_sent;

  // receiver stall pattern
  int ready_mode;
  int ready_left;

  sgs_pix_if  pix_if ();
  sgs_grad_if grad_if ();

  sobel_gradient_stream_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if),
    .grad_o     (grad_if)
  );

  sgs_grad_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pix_i        (pix_if),
    .grad_i       (grad_if),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt),
    .frame_left_o (frame_left)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: always ready, light stalls or heavy stalls, in random stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_if.ready <= 1'b0;
      ready_mode    <= 0;
      ready_left    <= 0;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_left <= $urandom_range(20, 200);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_mode)
        0:       grad_if.ready <= 1'b1;
        1:       grad_if.ready <= ($urandom_range(0, 3) != 0);
        default: grad_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel(pix_mix_e mix);
    logic [PIX_W-1:0] px;
    case (mix)
      PIX_BINARY:    px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_NEAR_RAIL: px = $urandom_range(0, 1) ? PIX_W'($urandom_range(240, 255))
                                               : PIX_W'($urandom_range(0, 15));
      default:       px = PIX_W'($urandom_range(0, 255));
    endcase
    return px;
  endfunction

  // One pixel request; bursts end with a random gap
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    pix_on = 1'b1;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    pix_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        pix_on = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_pixels(input int n, input pix_mix_e mix);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel(mix));
  endtask

  // Hold off until every predicted result is out, then let the pipe drain
  task automatic wait_idle();
    if (pix_on) begin
      pix_if.valid <= 1'b0;
      pix_on = 1'b0;
    end
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_val,
                           input logic [CFG_DATA_W-1:0] h_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_FRAME_WIDTH;
    cfg_data_i <= w_val;
    @(posedge clk_i);
    cfg_idx_i  <= REG_FRAME_HEIGHT;
    cfg_data_i <= h_val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [PIX_W-1:0] dir_pat [18];
    int               n;
    int               part;
    int               w_new;
    int               h_new;
    int               rand_base;
    pix_mix_e         mix;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_FRAME_WIDTH;
    cfg_data_i   <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    pix_on       = 1'b0;
    pix_sent     = 0;
    burst_left   = $urandom_range(1, 24);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size: one 640-pixel row and a bit, then shrink inside the frame
    send_pixels(645, PIX_ANY);
    wait_idle();
    set_frame(8, 3);
    send_pixels(frame_left, PIX_ANY);
    wait_idle();

    // Directed 3x3 frames: full positive horizontal, full negative vertical
    dir_pat = '{8'd0,   8'd128, 8'd255, 8'd0,  8'd128, 8'd255, 8'd0, 8'd128, 8'd255,
                8'd255, 8'd255, 8'd255, 8'd77, 8'd77,  8'd77,  8'd0, 8'd0,   8'd0};
    set_frame(3, 3);
    for (int i = 0; i < 18; i++) send_pixel(dir_pat[i]);
    wait_idle();

    // Sizes below the minimum clamp to 3x3
    set_frame(0, 2);
    send_pixels(frame_left, PIX_BINARY);
    wait_idle();

    // Tallest frame: twenty rows in, then cut the frame short
    set_frame(1, 4096);
    send_pixels(60, PIX_NEAR_RAIL);
    wait_idle();
    set_frame(3, 3);
    send_pixels(frame_left, PIX_NEAR_RAIL);
    wait_idle();

    // Oversize values clamp to the maximum; shrink partway through row one
    set_frame(2047, 8191);
    send_pixels(1030, PIX_ANY);
    wait_idle();
    set_frame(5, 4);
    send_pixels(frame_left, PIX_ANY);
    wait_idle();

    // Random small frames, some cut short, some streamed back to back
    rand_base = pix_sent;
    while (pix_sent - rand_base < RAND_ITEMS) begin
      case ($urandom_range(0, 19)) inside
        [0:15]:  w_new = $urandom_range(3, 12);
        [16:18]: w_new = $urandom_range(13, 64);
        default: w_new = $urandom_range(65, 200);
      endcase
      h_new = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8);
      mix   = pix_mix_e'($urandom_range(0, 2));
      set_frame(CFG_DATA_W'(w_new), CFG_DATA_W'(h_new));
      n = frame_left;
      case ($urandom_range(0, 3))
        0: begin
          // change height and narrow the row inside the frame
          part = $urandom_range(1, n - 1);
          send_pixels(part, mix);
          wait_idle();
          set_frame(CFG_DATA_W'($urandom_range(3, w_new)),
                    CFG_DATA_W'($urandom_range(3, 10)));
          send_pixels(frame_left, mix);
        end
        1:       send_pixels(2 * n, mix);
        default: send_pixels(n, mix);
      endcase
      wait_idle();
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("** sobel_gradient_stream_core: PASSED **");
    end else begin
      $display("** sobel_gradient_stream_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** sobel_gradient_stream_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/sgs_pkg.sv
src/sgs_stream_if.sv
src/sgs_front.sv
src/sgs_queue.sv
src/sgs_back.sv
src/sobel_gradient_stream_core.sv
tb/sgs_grad_checker.sv
tb/sobel_gradient_stream_core_tb.sv
